// File: rtl/fcs_pkg.sv
// Shared types and constants for the frame cosine similarity block.
// Used by every module in rtl/; depends on nothing.
package fcs_pkg;

  localparam int DotW    = 38;
  localparam int EnergyW = 37;
  localparam int WideW   = 108;
  localparam int QW      = 15;

  localparam logic signed [DotW-1:0] DotMax = {1'b0, {(DotW-1){1'b1}}};
  localparam logic signed [DotW-1:0] DotMin = {1'b1, {(DotW-1){1'b0}}};
  localparam logic [EnergyW-1:0]     EnergyMax = {EnergyW{1'b1}};
  localparam logic [QW-1:0]          ScoreOne = 15'd16384;

  typedef struct packed {
    logic signed [15:0] coef_a;
    logic signed [15:0] coef_b;
    logic               frame_end;
  } pair_t;

  typedef struct packed {
    logic signed [15:0] score;
    logic               zero_norm;
  } result_t;

  // Accumulated totals of one finished frame.
  typedef struct packed {
    logic signed [DotW-1:0] dot_sum;
    logic [EnergyW-1:0]     energy_a;
    logic [EnergyW-1:0]     energy_b;
  } frame_sums_t;

endpackage

// File: rtl/frame_cosine_similarity.sv
// Top level of the frame cosine similarity block.
// Depends on fcs_pkg, fcs_accum, fcs_queue and fcs_score.
//
//   Channel   Direction  Handshake                    Payload
//   pair      in         pair_valid / pair_stall      fcs_pkg::pair_t
//   result    out        result_valid / result_stall  fcs_pkg::result_t
//
// Coefficient pairs are taken one per cycle; each transfer is folded into
// saturating accumulators at once. The back end scores each frame with an
// 8-bit-per-cycle shared multiplier, run for the two setup products and
// fifteen times in the bitwise search; a zero-energy frame skips both. A
// two-entry queue holds finished frames, so pair transfers stall only when
// it is full. Reset is synchronous, active high.
module frame_cosine_similarity (
  input  logic              clk,
  input  logic              rst,
  input  logic              pair_valid,
  output logic              pair_stall,
  input  fcs_pkg::pair_t    pair,
  output logic              result_valid,
  input  logic              result_stall,
  output fcs_pkg::result_t  result
);
  import fcs_pkg::*;

  logic        push;
  logic        full;
  logic        pop;
  logic        not_empty;
  frame_sums_t push_data;
  frame_sums_t pop_data;

  fcs_accum u_accum (
    .clk, .rst, .pair_valid, .pair_stall, .pair,
    .push, .push_data, .full
  );

  fcs_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .pop, .not_empty, .pop_data
  );

  fcs_score u_score (
    .clk, .rst, .not_empty, .frame(pop_data), .pop,
    .result_valid, .result_stall, .result
  );

endmodule

// File: rtl/fcs_accum.sv
// Front end: accumulates dot product and energies, one coefficient pair per cycle unless the full queue stalls it.
// Depends on fcs_pkg.
module fcs_accum (
  input  logic                clk,
  input  logic                rst,
  input  logic                pair_valid,
  output logic                pair_stall,
  input  fcs_pkg::pair_t      pair,
  output logic                push,
  output fcs_pkg::frame_sums_t push_data,
  input  logic                full
);
  import fcs_pkg::*;

  logic signed [DotW-1:0]  dot_sum;
  logic [EnergyW-1:0]      energy_a;
  logic [EnergyW-1:0]      energy_b;
  logic signed [DotW-1:0]  dot_next;
  logic [EnergyW-1:0]      energy_a_next;
  logic [EnergyW-1:0]      energy_b_next;
  logic signed [31:0]      prod;
  logic [30:0]             sq_a;
  logic [30:0]             sq_b;
  logic signed [DotW:0]    dot_wide;
  logic [EnergyW:0]        ea_wide;
  logic [EnergyW:0]        eb_wide;
  logic                    accept;

  assign pair_stall = full;
  assign accept     = pair_valid && !full;

  // Saturating accumulation including the current pair.
  always_comb begin
    prod     = pair.coef_a * pair.coef_b;
    sq_a     = 31'(pair.coef_a * pair.coef_a);
    sq_b     = 31'(pair.coef_b * pair.coef_b);
    dot_wide = (DotW+1)'(dot_sum) + (DotW+1)'(prod);
    ea_wide  = (EnergyW+1)'(energy_a) + (EnergyW+1)'(sq_a);
    eb_wide  = (EnergyW+1)'(energy_b) + (EnergyW+1)'(sq_b);
    if (dot_wide > (DotW+1)'(DotMax)) begin
      dot_next = DotMax;
    end else if (dot_wide < (DotW+1)'(DotMin)) begin
      dot_next = DotMin;
    end else begin
      dot_next = dot_wide[DotW-1:0];
    end
    energy_a_next = ea_wide[EnergyW] ? EnergyMax : ea_wide[EnergyW-1:0];
    energy_b_next = eb_wide[EnergyW] ? EnergyMax : eb_wide[EnergyW-1:0];
  end

  assign push               = accept && pair.frame_end;
  assign push_data.dot_sum  = dot_next;
  assign push_data.energy_a = energy_a_next;
  assign push_data.energy_b = energy_b_next;

  // Accumulators clear after the last pair of a frame.
  always_ff @(posedge clk) begin
    if (rst || push) begin
      dot_sum  <= '0;
      energy_a <= '0;
      energy_b <= '0;
    end else if (accept) begin
      dot_sum  <= dot_next;
      energy_a <= energy_a_next;
      energy_b <= energy_b_next;
    end
  end

endmodule

// File: rtl/fcs_queue.sv
// Two-entry queue of finished frame totals between front and back ends.
// Depends on fcs_pkg.
module fcs_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  fcs_pkg::frame_sums_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output fcs_pkg::frame_sums_t pop_data
);
  import fcs_pkg::*;

  frame_sums_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/fcs_score.sv
// Back end: computes the rounded Q1.14 score of one frame with a shared
// shift-add multiplier (8 bits per cycle) and a bitwise search. Depends on fcs_pkg.
module fcs_score (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 not_empty,
  input  fcs_pkg::frame_sums_t frame,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output fcs_pkg::result_t     result
);
  import fcs_pkg::*;

  typedef enum logic [2:0] {
    IDLE, MUL_P, MUL_D, SQUARE, MUL_L, COMPARE, DONE
  } state_t;

  state_t              state;
  logic [WideW-1:0]    acc;
  logic [WideW-1:0]    acc_next;
  logic [WideW-1:0]    mcand;
  logic [DotW-1:0]     mplier;
  logic [2:0]          step;
  logic [WideW-1:0]    prod;
  logic [WideW-1:0]    rhs;
  logic [DotW-1:0]     mag;
  logic                neg;
  logic                zero;
  logic [QW-1:0]       q;
  logic [QW-1:0]       cand;
  logic [3:0]          bit_idx;
  logic [15:0]         odd;
  logic [WideW-1:0]    partial;
  logic [QW-1:0]       q_clamp;
  logic                out_free;

  assign partial  = mcand * mplier[7:0];
  assign acc_next = acc + partial;
  assign cand     = q | (QW'(1) << bit_idx);
  assign odd      = {cand, 1'b0} - 16'd1;
  assign q_clamp  = (q > ScoreOne) ? ScoreOne : q;
  assign out_free = !result_valid || !result_stall;
  assign pop      = (state == IDLE) && not_empty;

  // Sequencer, multiplier registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (not_empty) begin
            neg    <= frame.dot_sum[DotW-1];
            mag    <= frame.dot_sum[DotW-1] ? DotW'(-frame.dot_sum) : frame.dot_sum;
            zero   <= (frame.energy_a == '0) || (frame.energy_b == '0);
            acc    <= '0;
            mcand  <= WideW'(frame.energy_a);
            mplier <= DotW'(frame.energy_b);
            step   <= 3'd0;
            q      <= '0;
            state  <= ((frame.energy_a == '0) || (frame.energy_b == '0)) ? DONE : MUL_P;
          end
        end
        MUL_P: begin
          if (step == 3'd4) begin
            prod   <= acc_next;
            acc    <= '0;
            mcand  <= WideW'(mag);
            mplier <= mag;
            step   <= 3'd0;
            state  <= MUL_D;
          end else begin
            acc    <= acc_next;
            mcand  <= mcand << 8;
            mplier <= mplier >> 8;
            step   <= step + 3'd1;
          end
        end
        MUL_D: begin
          if (step == 3'd4) begin
            rhs     <= acc_next << 30;
            bit_idx <= 4'd14;
            state   <= SQUARE;
          end else begin
            acc    <= acc_next;
            mcand  <= mcand << 8;
            mplier <= mplier >> 8;
            step   <= step + 3'd1;
          end
        end
        SQUARE: begin
          acc    <= '0;
          mcand  <= prod;
          mplier <= DotW'(odd * odd);
          step   <= 3'd0;
          state  <= MUL_L;
        end
        MUL_L: begin
          acc    <= acc_next;
          mcand  <= mcand << 8;
          mplier <= mplier >> 8;
          step   <= step + 3'd1;
          if (step == 3'd4) begin
            state <= COMPARE;
          end
        end
        COMPARE: begin
          if (acc <= rhs) begin
            q <= cand;
          end
          if (bit_idx == 4'd0) begin
            state <= DONE;
          end else begin
            bit_idx <= bit_idx - 4'd1;
            state   <= SQUARE;
          end
        end
        DONE: begin
          if (out_free) begin
            result_valid     <= 1'b1;
            result.zero_norm <= zero;
            if (zero) begin
              result.score <= '0;
            end else begin
              result.score <= neg ? -16'(q_clamp) : 16'(q_clamp);
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
